// ===== rtl/svt_pkg.sv =====
// Shared types, opcodes and constant tables for the sine voice block.
// Holds the note phase-step ROM and the quarter-wave sine ROM, both built
// at elaboration. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svt_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SAMPLE_RATE_HZ = 48000;

  localparam logic [1:0] OP_NOTE_ON   = 2'd0;
  localparam logic [1:0] OP_NOTE_REL  = 2'd1;
  localparam logic [1:0] OP_NOTE_KILL = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam int GAIN_BITS = 25;
  localparam int AMP_BITS  = 14;
  localparam int MAG_BITS  = 15;
  localparam int MUL_BITS  = 25;

  localparam logic [GAIN_BITS-1:0] TAIL_ONE   = 25'd16777216;
  localparam logic [23:0]          TAIL_DECAY = 24'd16768827;
  localparam logic [GAIN_BITS-1:0] TAIL_STOP  = 25'd83886;

  // extra fraction bits carried by the base steps, one per octave
  localparam int OCT_EXT = 10;
  localparam logic [63:0] PICO_DEN = 64'(SAMPLE_RATE_HZ) * 64'd1000000000000;

  localparam int QADDR_BITS = SINE_ADDR_BITS - 2;
  localparam int QSIZE      = 1 << QADDR_BITS;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  note_number;
    logic [15:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               voice_active;
  } out_item_t;

  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } sine_t;

  typedef logic [PHASE_BITS-1:0] step_rom_t [128];
  typedef logic [MAG_BITS-1:0]   qsine_rom_t [QSIZE];

  function automatic logic [63:0] base_freq_pico(input int k);
    logic [63:0] f;
    case (k)
      0:       f = 64'd8175798915644;
      1:       f = 64'd8661957218027;
      2:       f = 64'd9177023997419;
      3:       f = 64'd9722718241315;
      4:       f = 64'd10300861153527;
      5:       f = 64'd10913382232281;
      6:       f = 64'd11562325709739;
      7:       f = 64'd12249857374430;
      8:       f = 64'd12978271799373;
      9:       f = 64'd13750000000000;
      10:      f = 64'd14567617547440;
      default: f = 64'd15433853164254;
    endcase
    return f;
  endfunction

  // floor(freq * 2^(PHASE_BITS+OCT_EXT) / den) by restoring long division
  function automatic logic [63:0] base_step_ext(input int k);
    logic [63:0] q;
    logic [63:0] r;
    q = 64'd0;
    r = base_freq_pico(k);
    for (int i = 0; i < PHASE_BITS + OCT_EXT; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= PICO_DEN) begin
        r = r - PICO_DEN;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic step_rom_t build_step_rom();
    step_rom_t   rom;
    logic [63:0] ext;
    for (int n = 0; n < 128; n++) begin
      ext = base_step_ext(n % 12);
      ext = ext >> (OCT_EXT - n / 12);
      rom[n] = ext[PHASE_BITS-1:0];
    end
    return rom;
  endfunction

  // rounded magnitude of sin(pi/2 * r/QSIZE) * 32767, Taylor series in Q30
  function automatic logic [MAG_BITS-1:0] sine_mag(input int r);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] m;
    x  = 64'(r) << (30 - QADDR_BITS);
    t  = (x * HALF_PI_Q30) >> 30;
    t2 = (t * t) >> 30;
    h  = Q30_ONE;
    h  = Q30_ONE - ((t2 * h) >> 30) / 110;
    h  = Q30_ONE - ((t2 * h) >> 30) / 72;
    h  = Q30_ONE - ((t2 * h) >> 30) / 42;
    h  = Q30_ONE - ((t2 * h) >> 30) / 20;
    h  = Q30_ONE - ((t2 * h) >> 30) / 6;
    s  = (t * h) >> 30;
    m  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (m > 64'd32767) m = 64'd32767;
    return m[MAG_BITS-1:0];
  endfunction

  function automatic qsine_rom_t build_qsine_rom();
    qsine_rom_t rom;
    for (int r = 0; r < QSIZE; r++) rom[r] = sine_mag(r);
    return rom;
  endfunction

  localparam step_rom_t           STEP_ROM   = build_step_rom();
  localparam qsine_rom_t          QSINE_ROM  = build_qsine_rom();
  localparam logic [MAG_BITS-1:0] QSINE_PEAK = sine_mag(QSIZE);

endpackage

`default_nettype wire

// ===== rtl/svt_sine_rom.sv =====
// Registered sine lookup: top phase bits to sign and magnitude.
// Quarter-wave table from svt_pkg with mirror and sign by quadrant.
`timescale 1ns / 1ps
`default_nettype none

module svt_sine_rom
  import svt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic [SINE_ADDR_BITS-1:0] addr,
  output sine_t                          sine
);

  logic [1:0]            quad;
  logic [QADDR_BITS-1:0] r;
  logic [QADDR_BITS-1:0] r_mirror;
  sine_t                 sine_r;
  sine_t                 sine_nxt;

  assign quad     = addr[SINE_ADDR_BITS-1 -: 2];
  assign r        = addr[QADDR_BITS-1:0];
  assign r_mirror = ~r + 1'b1;   // QSIZE - r, mod QSIZE

  always_comb begin
    sine_nxt.neg = quad[1];
    if (!quad[0]) begin
      sine_nxt.mag = QSINE_ROM[r];
    end else if (r == '0) begin
      sine_nxt.mag = QSINE_PEAK;   // mirrored index lands on the quarter point
    end else begin
      sine_nxt.mag = QSINE_ROM[r_mirror];
    end
  end

  always_ff @(posedge clk) begin
    sine_r <= sine_nxt;
  end

  assign sine = sine_r;

endmodule

`default_nettype wire

// ===== rtl/sine_voice_with_tail_decay.sv =====
// Top level of the sine voice: sequencer, shared multiplier, voice state.
// Uses svt_pkg and svt_sine_rom.
//
//   channel | ports                          | payload
//   --------+--------------------------------+-----------------------
//   input   | in_valid, in_ready, in_data    | in_item_t  (opcode, note, velocity)
//   output  | out_valid, out_ready, out_data | out_item_t (sample, active)
//
// Note on / note off: done at the transfer edge.
// Tick: idle to S_OUT, sounding via S_M1, releasing via S_M1 to S_M3; one 25x25
// multiplier is shared by the level, tail and decay products, one per cycle.
// The output register holds one result; a tick waits in its last step while
// that register is still full. Synchronous active-low reset clears the voice.
`timescale 1ns / 1ps
`default_nettype none

module sine_voice_with_tail_decay
  import svt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_item_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_M2   = 3'd2;
  localparam logic [2:0] S_M3   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state_r,    state_nxt;
  logic [PHASE_BITS-1:0] phase_r,    phase_nxt;
  logic [PHASE_BITS-1:0] step_r,     step_nxt;
  logic [AMP_BITS-1:0]   amp_r,      amp_nxt;
  logic [GAIN_BITS-1:0]  gain_r,     gain_nxt;
  logic                  sounding_r, sounding_nxt;
  logic [15:0]           m_r,        m_nxt;
  out_item_t             res_r,      res_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  in_xfer;
  logic                  out_free;
  logic [MUL_BITS-1:0]   mul_a;
  logic [MUL_BITS-1:0]   mul_b;
  logic [2*MUL_BITS-1:0] mul_p;
  logic [GAIN_BITS-1:0]  gain_dec;
  logic [15:0]           m_signed;
  sine_t                 sine;

  svt_sine_rom u_sine (
    .clk  (clk),
    .addr (phase_r[PHASE_BITS-1 -: SINE_ADDR_BITS]),
    .sine (sine)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M1: begin
        mul_a = MUL_BITS'(sine.mag);
        mul_b = MUL_BITS'(amp_r);
      end
      S_M2: begin
        mul_a = MUL_BITS'(m_r);
        mul_b = gain_r;
      end
      S_M3: begin
        mul_a = gain_r;
        mul_b = MUL_BITS'(TAIL_DECAY);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign gain_dec = mul_p[GAIN_BITS+23:24];
  assign m_signed = sine.neg ? (16'd0 - m_r) : m_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    amp_nxt       = amp_r;
    gain_nxt      = gain_r;
    sounding_nxt  = sounding_r;
    m_nxt         = m_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_data.opcode)
            OP_NOTE_ON: begin
              phase_nxt    = '0;
              amp_nxt      = in_data.velocity[15:2];
              gain_nxt     = '0;
              step_nxt     = STEP_ROM[in_data.note_number];
              sounding_nxt = 1'b1;
            end
            OP_NOTE_REL: begin
              if (gain_r == '0) gain_nxt = TAIL_ONE;
            end
            OP_NOTE_KILL: begin
              sounding_nxt = 1'b0;
              step_nxt     = '0;
            end
            OP_TICK: begin
              res_nxt   = '0;
              state_nxt = sounding_r ? S_M1 : S_OUT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_M1: begin
        m_nxt = mul_p[31:16];
        if (gain_r != '0) begin
          state_nxt = S_M2;
        end else begin
          res_nxt.sample_out   = sine.neg ? (16'd0 - mul_p[31:16]) : mul_p[31:16];
          res_nxt.voice_active = 1'b1;
          phase_nxt            = phase_r + step_r;
          state_nxt            = S_OUT;
        end
      end
      S_M2: begin
        m_nxt     = mul_p[39:24];
        state_nxt = S_M3;
      end
      S_M3: begin
        gain_nxt = gain_dec;
        // tail end: silent sample, phase holds, tail keeps its small value
        if (gain_dec <= TAIL_STOP) begin
          sounding_nxt = 1'b0;
          step_nxt     = '0;
        end else begin
          res_nxt.sample_out   = m_signed;
          res_nxt.voice_active = 1'b1;
          phase_nxt            = phase_r + step_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      step_r      <= '0;
      amp_r       <= '0;
      gain_r      <= '0;
      sounding_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      amp_r       <= amp_nxt;
      gain_r      <= gain_nxt;
      sounding_r  <= sounding_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !sounding_r |-> (step_r == '0))
    else $error("voice idle with nonzero phase step");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= TAIL_ONE)
    else $error("release tail above 1.0");

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.voice_active) |-> (out_data_r.sample_out == 16'sd0))
    else $error("inactive result with nonzero sample");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.opcode == OP_TICK && !sounding_r) |=> (state_r == S_OUT))
    else $error("idle tick did not go straight to output");
`endif

endmodule

`default_nettype wire
